// File: hdl/rec_pkg.sv
package rec_pkg;

  // Datapath widths
  localparam int COUNT_WIDTH = 16;
  localparam int TIME_WIDTH  = 32;
  localparam int HOLD_WIDTH  = 10;
  localparam int INC_WIDTH   = 3;

  // Stream payload widths, padded to whole bytes
  localparam int IN_FIELD_BITS   = TIME_WIDTH + 2;
  localparam int IN_TDATA_WIDTH  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS  = COUNT_WIDTH + 2;
  localparam int OUT_TDATA_WIDTH = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Hold time after reset
  localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = HOLD_WIDTH'(50);

  // Acceleration curve
  localparam logic [TIME_WIDTH-1:0] FAST_GAP_MS = TIME_WIDTH'(12);
  localparam logic [3:0]            ACCEL_BASE  = 4'd14;

  // Count limits
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  // Request kind carried in tuser
  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_REPORT = 1'b1
  } rec_mode_t;

  // Direction codes
  typedef enum logic {
    DIR_LEFT  = 1'b0,
    DIR_RIGHT = 1'b1
  } rec_dir_t;

  // One result item
  typedef struct packed {
    logic                   turn_dir;
    logic                   changed;
    logic [COUNT_WIDTH-1:0] step_count;
  } rec_result_t;

endpackage

// File: hdl/rec_step.sv
module rec_step (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  rec_pkg::rec_mode_t             mode,
  input  logic [rec_pkg::TIME_WIDTH-1:0] now_ms,
  input  logic                           chan_a,
  input  logic                           chan_b,
  input  logic [rec_pkg::HOLD_WIDTH-1:0] hold_ms,
  output rec_pkg::rec_result_t           result
);
  import rec_pkg::*;

  logic [TIME_WIDTH-1:0]  last_edge_r, last_edge_nxt;
  logic                   last_a_r, last_a_nxt;
  logic                   half_r, half_nxt;
  logic                   dir_r, dir_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   changed_r, changed_nxt;

  logic [TIME_WIDTH-1:0]  gap;
  logic [3:0]             accel_diff;
  logic [INC_WIDTH-1:0]   inc;
  logic                   cand;
  logic                   step_dir;
  logic [COUNT_WIDTH:0]   count_ext;
  logic [COUNT_WIDTH:0]   inc_ext;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sum_sat;

  // Edge gap and acceleration step
  assign gap        = now_ms - last_edge_r;
  assign accel_diff = ACCEL_BASE - gap[3:0];
  assign inc        = (gap < FAST_GAP_MS) ? accel_diff[3:1] : INC_WIDTH'(1);
  assign cand       = (chan_b != last_a_r);

  // Adopt the candidate direction only once the hold time has passed
  assign step_dir   = (cand != dir_r && gap > TIME_WIDTH'(hold_ms)) ? cand : dir_r;

  // Add or subtract the step on the new direction, then clamp
  assign count_ext = {count_r[COUNT_WIDTH-1], count_r};
  assign inc_ext   = (COUNT_WIDTH+1)'(inc);
  assign sum       = (step_dir == DIR_RIGHT) ? count_ext - inc_ext : count_ext + inc_ext;
  always_comb begin
    if (sum[COUNT_WIDTH] != sum[COUNT_WIDTH-1]) begin
      sum_sat = sum[COUNT_WIDTH] ? COUNT_MIN : COUNT_MAX;
    end else begin
      sum_sat = sum[COUNT_WIDTH-1:0];
    end
  end

  // Next state and result for one request
  always_comb begin
    last_edge_nxt = last_edge_r;
    last_a_nxt    = last_a_r;
    half_nxt      = half_r;
    dir_nxt       = dir_r;
    count_nxt     = count_r;
    changed_nxt   = changed_r;
    result.step_count = count_r;
    result.changed    = changed_r;
    result.turn_dir   = dir_r;
    if (mode == MODE_REPORT) begin
      count_nxt   = '0;
      changed_nxt = 1'b0;
    end else begin
      if (chan_a != last_a_r) begin
        half_nxt = ~half_r;
        dir_nxt  = step_dir;
        if (!half_r) begin
          count_nxt   = sum_sat;
          changed_nxt = 1'b1;
        end
        last_edge_nxt = now_ms;
        last_a_nxt    = chan_a;
      end
      result.step_count = count_nxt;
      result.changed    = changed_nxt;
      result.turn_dir   = dir_nxt;
    end
  end

  // Commit state on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      last_a_r    <= 1'b0;
      half_r      <= 1'b0;
      dir_r       <= DIR_LEFT;
      count_r     <= '0;
      changed_r   <= 1'b0;
    end else if (accept) begin
      last_edge_r <= last_edge_nxt;
      last_a_r    <= last_a_nxt;
      half_r      <= half_nxt;
      dir_r       <= dir_nxt;
      count_r     <= count_nxt;
      changed_r   <= changed_nxt;
    end
  end

endmodule

// File: hdl/rec_out_buf.sv
module rec_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rec_pkg::rec_result_t push_data,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rec_pkg::rec_result_t out_data
);
  import rec_pkg::*;

  rec_result_t ent_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign space     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rptr_r];
  assign pop       = out_valid && out_ready;

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold result payloads
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/rotary_encoder_accel_counter_unit.sv
// Timing: a result is written into the two-entry result queue when its request
// is accepted and is presented from there. Throughput: one request per cycle while
// the queue has space; the step logic and state update finish in the accept cycle,
// and the queue keeps input ready while a result waits downstream.
// Reset (rst_n low, synchronous): count, changed flag, edge state and queue
// clear, direction goes left and the hold time returns to 50 ms.
module rotary_encoder_accel_counter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration: direction hold time in ms
  input  logic                                cfg_wr_en,
  input  logic [rec_pkg::HOLD_WIDTH-1:0]      cfg_wr_data,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rec_pkg::IN_TDATA_WIDTH-1:0]  in_tdata,  // now_ms, chan_a, chan_b
  input  logic                                in_tuser,  // mode
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rec_pkg::OUT_TDATA_WIDTH-1:0] out_tdata  // step_count, changed, turn_dir
);
  import rec_pkg::*;

  logic [HOLD_WIDTH-1:0] hold_r;
  logic                  in_accept;
  rec_mode_t             mode;
  rec_result_t           step_res;
  rec_result_t           out_res;

  // Hold time register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_RESET;
    end else if (cfg_wr_en) begin
      hold_r <= cfg_wr_data;
    end
  end

  assign in_accept = in_tvalid && in_tready;
  assign mode      = rec_mode_t'(in_tuser);

  rec_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .mode    (mode),
    .now_ms  (in_tdata[TIME_WIDTH-1:0]),
    .chan_a  (in_tdata[TIME_WIDTH]),
    .chan_b  (in_tdata[TIME_WIDTH+1]),
    .hold_ms (hold_r),
    .result  (step_res)
  );

  rec_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (step_res),
    .space     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack result fields, zero padding on top
  assign out_tdata = OUT_TDATA_WIDTH'(out_res);

endmodule
